/* rtl/core/tre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types, constants and helpers of the targa RLE pixel encoder.
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int MAX_PACKET_DEF   = 128;
    localparam int GROUP_PIXELS_DEF = 4;
    localparam int MAX_RESULTS      = 34;
    localparam int CMDQ_DEPTH       = 4;
    localparam int CMDQ_AW          = $clog2(CMDQ_DEPTH);
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE   = 1'b1;

    localparam logic [7:0] RUN_FLAG = 8'h80;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
    } t_pix_in;

    typedef struct packed {
        logic        is_header;
        logic [7:0]  header_byte;
        logic [2:0]  group_count;
        logic [31:0] pixel_a;
        logic [31:0] pixel_b;
        logic [31:0] pixel_c;
        logic [31:0] pixel_d;
        logic        last_result;
    } t_pix_out;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_RUN,
        CMD_RAW
    } t_cmd_kind;

    // One packet job handed from the classifier to the emitter.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  count;
        logic [31:0] pixel;
        logic        last;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_HEAD,
        BS_PIXEL,
        BS_FETCH,
        BS_DRAIN,
        BS_SEND
    } t_back_state;

    // Raw packets close early so one pixel never causes too many results.
    function automatic int f_raw_limit(input int max_packet, input int group_pixels);
        int lim;
        lim = (MAX_RESULTS - 3) * group_pixels;
        return (max_packet < lim) ? max_packet : lim;
    endfunction

    function automatic t_cmd f_make_cmd(input t_cmd_kind kind, input logic [7:0] count,
                                        input logic [31:0] pixel, input logic last);
        t_cmd c;
        c.kind  = kind;
        c.count = count;
        c.pixel = pixel;
        c.last  = last;
        return c;
    endfunction

endpackage

/* rtl/core/tre_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_cmd_fifo
// Small command queue between classifier and emitter; takes up to two
// commands per cycle, gives one.
// ----------------------------------------------------------------------------
module tre_cmd_fifo
    import tre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_cmd       i_cmd0,
    input  t_cmd       i_cmd1,
    output logic       o_space_ok,
    output logic       o_valid,
    output t_cmd       o_head,
    input  logic       i_pop
);

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, n_wp;
    logic [CMDQ_AW-1:0] r_rp, n_rp;
    logic [CMDQ_AW:0]   r_cnt, n_cnt;
    logic [CMDQ_AW-1:0] wp_next;

    assign wp_next    = r_wp + 1'b1;
    assign o_space_ok = (r_cnt <= (CMDQ_AW + 1)'(CMDQ_DEPTH - 2));
    assign o_valid    = (r_cnt != '0);
    assign o_head     = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp + CMDQ_AW'(i_push_cnt);
        n_rp  = i_pop ? (r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + (CMDQ_AW + 1)'(i_push_cnt) - (CMDQ_AW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_q[r_wp] <= i_cmd0;
        end
        if (i_push_cnt == 2'd2) begin
            r_q[wp_next] <= i_cmd1;
        end
    end

endmodule

/* rtl/core/tre_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_front
// Pixel classifier: tracks the open run or raw packet, writes raw pixels
// into the pixel ring and queues packet commands for the emitter.
// ----------------------------------------------------------------------------
module tre_front
    import tre_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF,
    parameter int RAW_LIMIT  = f_raw_limit(MAX_PACKET_DEF, GROUP_PIXELS_DEF),
    parameter int STORE_AW   = $clog2(2 * f_raw_limit(MAX_PACKET_DEF, GROUP_PIXELS_DEF))
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_pix_in             i_pixel,
    input  logic                i_alpha_en,
    input  logic                i_rle_en,
    input  logic [STORE_AW:0]   i_rd_ptr,
    output logic                o_wr_en,
    output logic [STORE_AW-1:0] o_wr_addr,
    output logic [31:0]         o_wr_data,
    input  logic                i_q_space_ok,
    output logic [1:0]          o_push_cnt,
    output t_cmd                o_cmd0,
    output t_cmd                o_cmd1
);

    localparam logic [7:0] MAX8 = 8'(MAX_PACKET);
    localparam logic [7:0] LIM8 = 8'(RAW_LIMIT);

    logic [31:0]       r_held, n_held;
    logic              r_held_valid, n_held_valid;
    logic              r_in_run, n_in_run;
    logic [7:0]        r_run_len, n_run_len;
    logic [7:0]        r_raw_cnt, n_raw_cnt;
    logic [STORE_AW:0] r_wr_ptr, n_wr_ptr;
    logic              r_tail, n_tail;

    logic [31:0] pix;
    logic        same;
    logic        store_full;
    logic        accept;
    logic        tail_go;
    logic [7:0]  raw_next;

    always_comb begin
        pix        = {(i_alpha_en ? i_pixel.alpha : 8'h00),
                      i_pixel.red, i_pixel.green, i_pixel.blue};
        same       = (pix == r_held);
        store_full = (r_wr_ptr[STORE_AW] != i_rd_ptr[STORE_AW]) &&
                     (r_wr_ptr[STORE_AW-1:0] == i_rd_ptr[STORE_AW-1:0]);
        o_in_ready = !r_tail && i_q_space_ok && !store_full;
        accept     = i_in_valid && o_in_ready;
        tail_go    = r_tail && i_q_space_ok && !store_full;
        raw_next   = r_raw_cnt + 8'd1;

        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_in_run     = r_in_run;
        n_run_len    = r_run_len;
        n_raw_cnt    = r_raw_cnt;
        n_wr_ptr     = r_wr_ptr;
        n_tail       = r_tail;

        o_cmd0     = f_make_cmd(CMD_PASS, 8'd0, 32'd0, 1'b0);
        o_cmd1     = f_make_cmd(CMD_PASS, 8'd0, 32'd0, 1'b0);
        o_push_cnt = 2'd0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_wr_ptr[STORE_AW-1:0];
        o_wr_data  = r_held;

        if (tail_go) begin
            // close the row: finish the run, or push the held pixel and flush raw
            if (r_in_run) begin
                o_cmd0 = f_make_cmd(CMD_RUN, r_run_len, r_held, 1'b1);
            end else begin
                o_wr_en  = 1'b1;
                n_wr_ptr = r_wr_ptr + 1'b1;
                o_cmd0   = f_make_cmd(CMD_RAW, raw_next, 32'd0, 1'b1);
            end
            o_push_cnt   = 2'd1;
            n_raw_cnt    = 8'd0;
            n_held_valid = 1'b0;
            n_in_run     = 1'b0;
            n_run_len    = 8'd0;
            n_tail       = 1'b0;
        end else if (accept) begin
            if (!i_rle_en) begin
                o_cmd0     = f_make_cmd(CMD_PASS, 8'd1, pix, 1'b1);
                o_push_cnt = 2'd1;
            end else begin
                if (!r_held_valid) begin
                    n_held       = pix;
                    n_held_valid = 1'b1;
                    n_in_run     = 1'b0;
                    n_run_len    = 8'd0;
                end else if (r_in_run) begin
                    if (same) begin
                        if (r_run_len >= MAX8) begin
                            o_cmd0     = f_make_cmd(CMD_RUN, MAX8, r_held, 1'b0);
                            o_push_cnt = 2'd1;
                            n_run_len  = 8'd1;
                        end else begin
                            n_run_len = r_run_len + 8'd1;
                        end
                    end else begin
                        o_cmd0     = f_make_cmd(CMD_RUN, r_run_len, r_held, 1'b0);
                        o_push_cnt = 2'd1;
                        n_held     = pix;
                        n_in_run   = 1'b0;
                        n_run_len  = 8'd0;
                    end
                end else if (same) begin
                    // a run starts: the open raw packet closes first
                    if (r_raw_cnt != 8'd0) begin
                        o_cmd0     = f_make_cmd(CMD_RAW, r_raw_cnt, 32'd0, 1'b0);
                        o_push_cnt = 2'd1;
                        n_raw_cnt  = 8'd0;
                    end
                    n_in_run = 1'b1;
                    if (MAX8 <= 8'd1) begin
                        if (o_push_cnt == 2'd0) begin
                            o_cmd0 = f_make_cmd(CMD_RUN, MAX8, r_held, 1'b0);
                        end else begin
                            o_cmd1 = f_make_cmd(CMD_RUN, MAX8, r_held, 1'b0);
                        end
                        o_push_cnt = o_push_cnt + 2'd1;
                        n_run_len  = 8'd1;
                    end else begin
                        n_run_len = 8'd2;
                    end
                end else begin
                    o_wr_en  = 1'b1;
                    n_wr_ptr = r_wr_ptr + 1'b1;
                    n_held   = pix;
                    if (raw_next >= LIM8) begin
                        o_cmd0     = f_make_cmd(CMD_RAW, raw_next, 32'd0, 1'b0);
                        o_push_cnt = 2'd1;
                        n_raw_cnt  = 8'd0;
                    end else begin
                        n_raw_cnt = raw_next;
                    end
                end

                if (i_pixel.row_end) begin
                    n_tail = 1'b1;
                end else if (o_push_cnt == 2'd2) begin
                    o_cmd1.last = 1'b1;
                end else if (o_push_cnt == 2'd1) begin
                    o_cmd0.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_in_run     <= 1'b0;
            r_run_len    <= '0;
            r_raw_cnt    <= '0;
            r_wr_ptr     <= '0;
            r_tail       <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_in_run     <= n_in_run;
            r_run_len    <= n_run_len;
            r_raw_cnt    <= n_raw_cnt;
            r_wr_ptr     <= n_wr_ptr;
            r_tail       <= n_tail;
        end
    end

endmodule

/* rtl/core/tre_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_back
// Packet emitter: owns the raw pixel ring, turns queued commands into
// header and pixel-group results through an output register.
// ----------------------------------------------------------------------------
module tre_back
    import tre_pkg::*;
#(
    parameter int GROUP_PIXELS = GROUP_PIXELS_DEF,
    parameter int STORE_AW     = $clog2(2 * f_raw_limit(MAX_PACKET_DEF, GROUP_PIXELS_DEF))
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_q_head,
    output logic                o_q_pop,
    input  logic                i_wr_en,
    input  logic [STORE_AW-1:0] i_wr_addr,
    input  logic [31:0]         i_wr_data,
    output logic [STORE_AW:0]   o_rd_ptr,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_pix_out            o_result
);

    localparam int         STORE_DEPTH = 1 << STORE_AW;
    localparam logic [7:0] GRP8        = 8'(GROUP_PIXELS);
    localparam logic [2:0] GRP3        = 3'(GROUP_PIXELS);

    logic [31:0]       r_mem [STORE_DEPTH];
    logic [31:0]       r_mem_q;
    logic [31:0]       r_grp [4];

    t_back_state       r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [STORE_AW:0] r_rd_ptr, n_rd_ptr;
    logic [7:0]        r_remain, n_remain;
    logic [2:0]        r_grp_cnt, n_grp_cnt;
    logic [2:0]        r_k, n_k;
    logic              r_rd_valid;
    logic [1:0]        r_rd_slot;
    t_pix_out          r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic       slot_free;
    logic       load;
    logic       rd_en;
    logic [2:0] grp_next;

    assign o_rd_ptr    = r_rd_ptr;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        slot_free = !r_out_valid || i_out_ready;
        grp_next  = (r_remain < GRP8) ? r_remain[2:0] : GRP3;

        n_state   = r_state;
        n_cmd     = r_cmd;
        n_rd_ptr  = r_rd_ptr;
        n_remain  = r_remain;
        n_grp_cnt = r_grp_cnt;
        n_k       = r_k;
        n_out     = r_out;
        load      = 1'b0;
        rd_en     = 1'b0;
        o_q_pop   = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_cmd    = i_q_head;
                    n_remain = i_q_head.count;
                    n_state  = (i_q_head.kind == CMD_PASS) ? BS_PIXEL : BS_HEAD;
                end
            end
            BS_HEAD: begin
                if (slot_free) begin
                    load                = 1'b1;
                    n_out               = '0;
                    n_out.is_header     = 1'b1;
                    n_out.header_byte   = {1'b0, 7'(r_cmd.count - 8'd1)};
                    if (r_cmd.kind == CMD_RUN) begin
                        n_out.header_byte = RUN_FLAG | n_out.header_byte;
                        n_state           = BS_PIXEL;
                    end else begin
                        n_grp_cnt = grp_next;
                        n_k       = 3'd0;
                        n_state   = BS_FETCH;
                    end
                end
            end
            BS_PIXEL: begin
                if (slot_free) begin
                    load              = 1'b1;
                    n_out             = '0;
                    n_out.group_count = 3'd1;
                    n_out.pixel_a     = r_cmd.pixel;
                    n_out.last_result = r_cmd.last;
                    n_state           = BS_IDLE;
                end
            end
            BS_FETCH: begin
                // one ring read per cycle into the group slot r_k
                rd_en    = 1'b1;
                n_rd_ptr = r_rd_ptr + 1'b1;
                n_remain = r_remain - 8'd1;
                n_k      = r_k + 3'd1;
                if ((r_k + 3'd1) == r_grp_cnt) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                n_state = BS_SEND;
            end
            BS_SEND: begin
                if (slot_free) begin
                    load              = 1'b1;
                    n_out             = '0;
                    n_out.group_count = r_grp_cnt;
                    n_out.pixel_a     = (r_grp_cnt > 3'd0) ? r_grp[0] : 32'd0;
                    n_out.pixel_b     = (r_grp_cnt > 3'd1) ? r_grp[1] : 32'd0;
                    n_out.pixel_c     = (r_grp_cnt > 3'd2) ? r_grp[2] : 32'd0;
                    n_out.pixel_d     = (r_grp_cnt > 3'd3) ? r_grp[3] : 32'd0;
                    n_out.last_result = r_cmd.last && (r_remain == 8'd0);
                    if (r_remain == 8'd0) begin
                        n_state = BS_IDLE;
                    end else begin
                        n_grp_cnt = grp_next;
                        n_k       = 3'd0;
                        n_state   = BS_FETCH;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        n_out_valid = load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_remain  <= n_remain;
        r_grp_cnt <= n_grp_cnt;
        r_k       <= n_k;
        r_out     <= n_out;
        r_rd_slot <= r_k[1:0];
        if (r_rd_valid) begin
            r_grp[r_rd_slot] <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd_ptr[STORE_AW-1:0]];
        end
    end

endmodule

/* rtl/core/tga_rle_pixel_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder
// Targa run-length packet encoder: pixels in, packet headers and pixel
// groups of up to four out.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                   Payload
//  --------  ---  --------------------------  --------------------------------
//  pixel     in   i_in_valid / o_in_ready     i_pixel  (t_pix_in)
//  result    out  o_out_valid / i_out_ready   o_result (t_pix_out)
//  config    in   i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  The classifier takes one pixel request per cycle; it stalls only while it
//  closes a row's last packet, when the command queue has fewer than two free
//  slots, or when the raw pixel ring is full. The emitter runs behind it, one
//  command at a time: a run packet visits idle, header and pixel, a
//  pass-through pixel idle and pixel, a raw packet idle and header, then
//  fetch, drain and send per group, its pixels read one by one through the
//  ring's single read port. Reset is synchronous, active low; no clearing
//  pass is needed, the ring is only read where it was written. A stalled
//  output holds in its register while the classifier keeps taking pixels.
//
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder
    import tre_pkg::*;
#(
    parameter int MAX_PACKET   = MAX_PACKET_DEF,
    parameter int GROUP_PIXELS = GROUP_PIXELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_pix_in              i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_pix_out             o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data
);

    // Raw packets close at RAW_LIMIT pixels; the ring holds two of them so
    // the classifier can fill one while the emitter drains the other.
    localparam int RAW_LIMIT = f_raw_limit(MAX_PACKET, GROUP_PIXELS);
    localparam int STORE_AW  = $clog2(2 * RAW_LIMIT);

    logic r_alpha_en;
    logic r_rle_en;

    // front <-> queue <-> back
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [31:0]         wr_data;
    logic [STORE_AW:0]   rd_ptr;
    logic                q_space_ok;
    logic [1:0]          push_cnt;
    t_cmd                cmd0;
    t_cmd                cmd1;
    logic                q_valid;
    t_cmd                q_head;
    logic                q_pop;

    // Configuration registers; user writes only while block idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en <= 1'b1;
            r_rle_en   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA_ENABLE: r_alpha_en <= i_cfg_data;
                CFG_RLE_ENABLE:   r_rle_en   <= i_cfg_data;
                default:          r_rle_en   <= r_rle_en;
            endcase
        end
    end

    // Classifier: decides run / raw / pass-through and queues packet jobs.
    tre_front #(
        .MAX_PACKET (MAX_PACKET),
        .RAW_LIMIT  (RAW_LIMIT),
        .STORE_AW   (STORE_AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .i_alpha_en   (r_alpha_en),
        .i_rle_en     (r_rle_en),
        .i_rd_ptr     (rd_ptr),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_q_space_ok (q_space_ok),
        .o_push_cnt   (push_cnt),
        .o_cmd0       (cmd0),
        .o_cmd1       (cmd1)
    );

    // Decoupling queue: up to two jobs in, one job out per cycle.
    tre_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_cmd0     (cmd0),
        .i_cmd1     (cmd1),
        .o_space_ok (q_space_ok),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    // Emitter: headers, single pixels and raw groups read back from the ring.
    tre_back #(
        .GROUP_PIXELS (GROUP_PIXELS),
        .STORE_AW     (STORE_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_ptr    (rd_ptr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

/* dv/tb_tga_rle_pixel_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_encoder
// Self-checking bench for the targa RLE pixel encoder. Pixel requests are
// pushed through a bursty valid/ready driver. A cycle-free encoder model runs
// on every accepted pixel and queues the headers and pixel groups it expects.
// A monitor under random backpressure compares each result field by field.
// The run steps through every register setting. Config changes land mid-row
// so that held pixels carry across.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_encoder;
    import tre_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 9;
    // Worst emitter drain is a full raw packet of 31 groups.
    localparam int SETTLE_CYCLES    = 200;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_PHASE       = 4;
    localparam int RAW_CAP          =
        (MAX_PACKET_DEF < (MAX_RESULTS - 3) * GROUP_PIXELS_DEF) ?
        MAX_PACKET_DEF : (MAX_RESULTS - 3) * GROUP_PIXELS_DEF;
    localparam logic [7:0] COUNT_MASK = 8'h7f;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_pix_in              i_pixel    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_pix_out             o_result;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic                 i_cfg_data = 1'b0;

    tga_rle_pixel_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_pix_in  pixels_to_send[$];   // pending pixel requests, filled by the sequencer
    t_pix_out packet_items_due[$]; // expected results, oldest first
    t_pix_out step_items[$];       // results caused by the pixel being encoded
    t_pix_out want_result;

    int phase        = -1;
    int n_err        = 0;
    int n_pixels     = 0;
    int n_checked    = 0;
    int n_settings   = 0;
    int n_run_pkts   = 0;
    int n_raw_pkts   = 0;
    int n_pass       = 0;
    int idle_cycles  = 0;

    // driver / receiver private counters
    int   tx_burst_left = 0;
    int   tx_gap_left   = 0;
    logic tx_next_valid;
    t_pix_in tx_next_pix;
    int   rx_tick       = 0;
    int   rx_period     = 1;
    int   rx_duty       = 0;
    int   hold_left     = 0;
    bit   hold_done     = 1'b0;

    // ------------------------------------------------------------------
    // Encoder model: own copy of registers and packet state
    // ------------------------------------------------------------------
    bit          enc_alpha_en = 1'b1;
    bit          enc_rle_en   = 1'b1;
    logic [31:0] hold_pix     = '0;   // newest pixel, class decided by its successor
    bit          hold_ok      = 1'b0;
    bit          run_open     = 1'b0;
    int          run_cnt      = 0;    // open run length, held pixel included
    logic [31:0] raw_pix [0:127];     // pixels of the open raw packet
    int          raw_cnt      = 0;

    function automatic logic [31:0] pixel_word(input t_pix_in p);
        return {enc_alpha_en ? p.alpha : 8'h00, p.red, p.green, p.blue};
    endfunction

    function automatic void add_header(input logic [7:0] hdr);
        t_pix_out r;
        r             = '0;
        r.is_header   = 1'b1;
        r.header_byte = hdr;
        step_items.push_back(r);
    endfunction

    function automatic void add_group(input int cnt, input logic [31:0] a,
                                      input logic [31:0] b, input logic [31:0] c,
                                      input logic [31:0] d);
        t_pix_out r;
        r             = '0;
        r.group_count = 3'(cnt);
        r.pixel_a     = a;
        r.pixel_b     = b;
        r.pixel_c     = c;
        r.pixel_d     = d;
        step_items.push_back(r);
    endfunction

    function automatic void send_run(input int len, input logic [31:0] pix);
        add_header(RUN_FLAG | (8'(len - 1) & COUNT_MASK));
        add_group(1, pix, '0, '0, '0);
        n_run_pkts++;
    endfunction

    function automatic void flush_raw();
        logic [31:0] w [4];
        int cnt;
        if (raw_cnt == 0) return;
        add_header(8'(raw_cnt - 1) & COUNT_MASK);
        for (int i = 0; i < raw_cnt; i += cnt) begin
            cnt = (raw_cnt - i > GROUP_PIXELS_DEF) ? GROUP_PIXELS_DEF : raw_cnt - i;
            for (int k = 0; k < 4; k++) begin
                w[k] = (k < cnt) ? raw_pix[i + k] : '0;
            end
            add_group(cnt, w[0], w[1], w[2], w[3]);
        end
        raw_cnt = 0;
        n_raw_pkts++;
    endfunction

    // raw packets close early so that one pixel never causes too many results
    function automatic void push_raw(input logic [31:0] pix);
        raw_pix[raw_cnt] = pix;
        raw_cnt++;
        if (raw_cnt >= RAW_CAP) flush_raw();
    endfunction

    // long runs split into full packets; the remainder keeps going
    function automatic void grow_run();
        if (run_cnt >= MAX_PACKET_DEF) begin
            send_run(MAX_PACKET_DEF, hold_pix);
            run_cnt = 1;
        end else begin
            run_cnt++;
        end
    endfunction

    function automatic void encode_pixel(input t_pix_in p);
        logic [31:0] pix;
        t_pix_out    r;
        pix = pixel_word(p);
        step_items.delete();
        if (!enc_rle_en) begin
            // pass-through: packet state untouched
            add_group(1, pix, '0, '0, '0);
            n_pass++;
        end else begin
            if (!hold_ok) begin
                hold_pix = pix;
                hold_ok  = 1'b1;
                run_open = 1'b0;
                run_cnt  = 0;
            end else if (run_open) begin
                if (pix == hold_pix) begin
                    grow_run();
                end else begin
                    send_run(run_cnt, hold_pix);
                    hold_pix = pix;
                    run_open = 1'b0;
                    run_cnt  = 0;
                end
            end else if (pix == hold_pix) begin
                flush_raw();
                run_open = 1'b1;
                run_cnt  = 1;
                grow_run();
            end else begin
                push_raw(hold_pix);
                hold_pix = pix;
            end
            // row end closes whatever is open; a lone last pixel goes raw
            if (p.row_end) begin
                if (run_open) begin
                    send_run(run_cnt, hold_pix);
                end else begin
                    push_raw(hold_pix);
                    flush_raw();
                end
                hold_ok  = 1'b0;
                run_open = 1'b0;
                run_cnt  = 0;
            end
        end
        foreach (step_items[i]) begin
            r             = step_items[i];
            r.last_result = (i == step_items.size() - 1);
            packet_items_due.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Reset: held for RESET_CYCLES, released once
    // ------------------------------------------------------------------
    // (driven from the sequencer below)

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps; one NBA per signal
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            tx_next_valid = i_in_valid && !o_in_ready;
            tx_next_pix   = i_pixel;
            if (i_in_valid && o_in_ready) begin
                encode_pixel(i_pixel);
                n_pixels++;
            end
            if (!tx_next_valid && pixels_to_send.size() > 0) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                end else begin
                    tx_next_pix   = pixels_to_send.pop_front();
                    tx_next_valid = 1'b1;
                    if (tx_burst_left > 1) begin
                        tx_burst_left--;
                    end else begin
                        // mostly short bursts, now and then a long gap-free stretch
                        tx_burst_left = ($urandom_range(0, 7) == 0) ?
                                        $urandom_range(40, 120) : $urandom_range(1, 16);
                        if ($urandom_range(0, 2) == 0)
                            tx_gap_left = 0;
                        else if ($urandom_range(0, 9) == 0)
                            tx_gap_left = $urandom_range(10, 30);
                        else
                            tx_gap_left = $urandom_range(1, 4);
                    end
                end
            end
            i_in_valid <= tx_next_valid;
            i_pixel    <= tx_next_pix;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: duty-cycle stall pattern with a randomly re-picked period and
    // duty, plus one long hold-off at the start of the pressure phase
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (phase == HOLD_PHASE && !hold_done) begin
            hold_done   = 1'b1;
            hold_left   = LONG_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_tick % 96 == 0) begin
                rx_period = $urandom_range(1, 8);
                rx_duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
            end
            i_out_ready <= (rx_tick % rx_period) >= rx_duty;
            rx_tick++;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (packet_items_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_result);
                n_err++;
            end else begin
                want_result = packet_items_due.pop_front();
                check_field("is_header",   32'(want_result.is_header),
                            32'(o_result.is_header));
                check_field("header_byte", 32'(want_result.header_byte),
                            32'(o_result.header_byte));
                check_field("group_count", 32'(want_result.group_count),
                            32'(o_result.group_count));
                check_field("pixel_a",     want_result.pixel_a,     o_result.pixel_a);
                check_field("pixel_b",     want_result.pixel_b,     o_result.pixel_b);
                check_field("pixel_c",     want_result.pixel_c,     o_result.pixel_c);
                check_field("pixel_d",     want_result.pixel_d,     o_result.pixel_d);
                check_field("last_result", 32'(want_result.last_result),
                            32'(o_result.last_result));
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any request moving on either side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d pixels queued, %0d results outstanding",
                     $time, pixels_to_send.size(), packet_items_due.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a,
                                        input logic eol);
        t_pix_in p;
        p.red     = r;
        p.green   = g;
        p.blue    = b;
        p.alpha   = a;
        p.row_end = eol;
        pixels_to_send.push_back(p);
    endfunction

    // len copies of one random pixel; alpha may vary per copy (a run only
    // when alpha is disabled)
    function automatic void add_run(input int len, input bit noisy_alpha, input bit ends_row);
        logic [31:0] c;
        c = $urandom;
        for (int i = 0; i < len; i++) begin
            queue_pixel(c[23:16], c[15:8], c[7:0],
                        noisy_alpha ? 8'($urandom) : c[31:24],
                        ends_row && (i == len - 1));
        end
    endfunction

    function automatic void add_raw(input int len, input bit ends_row);
        for (int i = 0; i < len; i++) begin
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        ends_row && (i == len - 1));
        end
    endfunction

    // mostly well-formed rows of runs and raw stretches, some noise from
    // a two-color palette that differs only in alpha, with random row ends
    function automatic void gen_rows(input int n, input bit noisy_alpha);
        int          target;
        int          nseg;
        logic [31:0] c;
        target = pixels_to_send.size() + n;
        while (pixels_to_send.size() < target) begin
            if ($urandom_range(0, 9) < 7) begin
                nseg = $urandom_range(1, 5);
                for (int s = 0; s < nseg; s++) begin
                    if ($urandom_range(0, 1))
                        add_run($urandom_range(2, 8), noisy_alpha, s == nseg - 1);
                    else
                        add_raw($urandom_range(1, 6), s == nseg - 1);
                end
            end else begin
                c = $urandom;
                for (int k = $urandom_range(1, 10); k > 0; k--) begin
                    queue_pixel(c[23:16], c[15:8], c[7:0],
                                $urandom_range(0, 1) ? c[31:24] : ~c[31:24],
                                $urandom_range(0, 3) == 0);
                end
            end
        end
    endfunction

    // both registers written back to back, then the new phase starts
    task automatic start_phase(input int k, input bit alpha_on, input bit rle_on);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ALPHA_ENABLE;
        i_cfg_data <= alpha_on;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RLE_ENABLE;
        i_cfg_data <= rle_on;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        phase      <= k;
        enc_alpha_en = alpha_on;
        enc_rle_en   = rle_on;
        n_settings++;
        @(negedge i_clk);
    endtask

    // sender pauses until every expected result is back, then settles
    task automatic wait_drained();
        while (pixels_to_send.size() != 0 || i_in_valid || packet_items_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, rle and alpha on
        start_phase(0, 1'b1, 1'b1);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);   // lone pixel, all zero
        queue_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);   // lone pixel, all ones
        add_run(3, 1'b0, 1'b1);                          // run closed by row end
        add_raw(5, 1'b1);                                // raw, two groups
        add_run(2, 1'b0, 1'b0);                          // run, raw, run, lone tail
        add_raw(1, 1'b0);
        add_run(3, 1'b0, 1'b0);
        add_raw(1, 1'b1);
        add_run(2, 1'b0, 1'b1);                          // shortest run
        queue_pixel(8'h5a, 8'ha5, 8'h3c, 8'h00, 1'b0);   // differ only in alpha
        queue_pixel(8'h5a, 8'ha5, 8'h3c, 8'hff, 1'b1);
        add_run(2, 1'b0, 1'b0);                          // run straight into run
        add_run(2, 1'b0, 1'b1);
        wait_drained();

        // 24-bit: alpha differences vanish; phase ends mid-row
        start_phase(1, 1'b0, 1'b1);
        gen_rows(35, 1'b1);
        add_raw(3, 1'b0);
        wait_drained();

        // pass-through in both pixel modes; the open row stays parked
        start_phase(2, 1'b1, 1'b0);
        gen_rows(15, 1'b0);
        wait_drained();
        start_phase(3, 1'b0, 1'b0);
        gen_rows(10, 1'b1);
        wait_drained();

        // back to packets, finishing the parked row; receiver holds off
        // long enough for the block to back up and stall its input
        start_phase(HOLD_PHASE, 1'b1, 1'b1);
        gen_rows(60, 1'b0);
        add_run(3, 1'b0, 1'b0);
        wait_drained();

        // long run at or past the packet limit, then a raw stretch at or past the
        // raw limit; held 32-bit run meets 24-bit pixels first
        start_phase(5, 1'b0, 1'b1);
        add_run($urandom_range(128, 130), 1'b1, 1'b0);
        add_raw($urandom_range(124, 126), 1'b1);
        gen_rows(10, 1'b1);
        wait_drained();

        start_phase(6, 1'b1, 1'b1);
        gen_rows(10, 1'b0);
        wait_drained();

        $display("Covered %0d pixels over %0d register settings: %0d run and %0d raw packets,",
                 n_pixels, n_settings, n_run_pkts, n_raw_pkts);
        $display("%0d pass-through pixels; %0d results checked, %0d field errors.",
                 n_pass, n_checked, n_err);
        if (n_err == 0 && packet_items_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
